### src/tes_pkg.sv
package tes_pkg;

    localparam int MAX_ROWS_DEF = 1024;

    localparam int COORD_W     = 16;
    localparam int ROW_COUNT_W = 11;
    localparam int ROW_INDEX_W = 10;
    localparam int REQ_W       = 2;
    localparam int DELTA_W     = COORD_W + 1;
    localparam int D_W         = COORD_W + 4;

    localparam logic [ROW_COUNT_W-1:0] ROW_COUNT_RST = 11'd1024;

    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
    localparam logic [REQ_W-1:0] REQ_EDGE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic                        filled;
        logic signed [COORD_W-1:0]   left;
        logic signed [COORD_W-1:0]   right;
    } span_t;

    typedef struct packed {
        logic load;
        logic init;
        logic step;
    } walk_cmd_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      at_end;
    } walk_stat_t;

    typedef enum logic [3:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_CLEAR,
        ST_INIT,
        ST_PT_RD,
        ST_PT_WR,
        ST_RD_DATA,
        ST_DONE
    } state_t;

endpackage

### src/tes_span_mem.sv
module tes_span_mem #(
    parameter int MAX_ROWS = tes_pkg::MAX_ROWS_DEF
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [$clog2(MAX_ROWS)-1:0]   waddr,
    input  tes_pkg::span_t                wdata,
    input  logic [$clog2(MAX_ROWS)-1:0]   raddr,
    output tes_pkg::span_t                rdata
);
    import tes_pkg::*;

    span_t mem [MAX_ROWS];
    span_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/tes_walker.sv
module tes_walker (
    input  logic                clk,
    input  tes_pkg::walk_cmd_t  cmd,
    input  tes_pkg::coord_t     xa,
    input  tes_pkg::coord_t     ya,
    input  tes_pkg::coord_t     xb,
    input  tes_pkg::coord_t     yb,
    output tes_pkg::walk_stat_t stat
);
    import tes_pkg::*;

    coord_t                    x_reg;
    coord_t                    y_reg;
    coord_t                    yb_reg;
    logic                      sx_neg_reg;
    logic                      sy_neg_reg;
    logic [DELTA_W-1:0]        dx_reg;
    logic [DELTA_W-1:0]        dy_reg;
    logic                      steep_reg;
    logic signed [D_W-1:0]     step_e_reg;
    logic signed [D_W-1:0]     step_ne_reg;
    logic signed [D_W-1:0]     d_reg;

    logic signed [DELTA_W-1:0] diff_x;
    logic signed [DELTA_W-1:0] diff_y;
    logic [DELTA_W-1:0]        abs_x;
    logic [DELTA_W-1:0]        abs_y;
    logic signed [D_W-1:0]     dx_ext;
    logic signed [D_W-1:0]     dy_ext;
    logic                      steep;
    logic signed [D_W-1:0]     addend;
    logic                      d_le_zero;
    coord_t                    x_adv;
    coord_t                    y_adv;

    always_comb
    begin
        diff_x = $signed({xb[COORD_W-1], xb}) - $signed({xa[COORD_W-1], xa});
        diff_y = $signed({yb[COORD_W-1], yb}) - $signed({ya[COORD_W-1], ya});
        abs_x  = diff_x[DELTA_W-1] ? DELTA_W'(-diff_x) : DELTA_W'(diff_x);
        abs_y  = diff_y[DELTA_W-1] ? DELTA_W'(-diff_y) : DELTA_W'(diff_y);
        dx_ext = $signed(D_W'(dx_reg));
        dy_ext = $signed(D_W'(dy_reg));
        steep  = dy_reg > dx_reg;
    end

    // shared step adder
    always_comb
    begin
        d_le_zero = d_reg <= 0;
        addend    = d_le_zero ? step_e_reg : step_ne_reg;
        x_adv     = sx_neg_reg ? x_reg - 16'sd1 : x_reg + 16'sd1;
        y_adv     = sy_neg_reg ? y_reg - 16'sd1 : y_reg + 16'sd1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg      <= xa;
            y_reg      <= ya;
            yb_reg     <= yb;
            sx_neg_reg <= xa > xb;
            sy_neg_reg <= ya > yb;
            dx_reg     <= abs_x;
            dy_reg     <= abs_y;
        end
        else if (cmd.init)
        begin
            steep_reg <= steep;
            if (steep)
            begin
                step_e_reg  <= dx_ext <<< 1;
                step_ne_reg <= (dx_ext - dy_ext) <<< 1;
                d_reg       <= (dx_ext <<< 1) - dy_ext;
            end
            else
            begin
                step_e_reg  <= dy_ext <<< 1;
                step_ne_reg <= (dy_ext - dx_ext) <<< 1;
                d_reg       <= (dy_ext <<< 1) - dx_ext;
            end
        end
        else if (cmd.step)
        begin
            d_reg <= d_reg + addend;
            if (d_le_zero)
            begin
                if (steep_reg)
                begin
                    y_reg <= y_adv;
                end
                else
                begin
                    x_reg <= x_adv;
                end
            end
            else
            begin
                x_reg <= x_adv;
                y_reg <= y_adv;
            end
        end
    end

    assign stat.x      = x_reg;
    assign stat.y      = y_reg;
    assign stat.at_end = y_reg == yb_reg;

endmodule

### src/tes_ctrl.sv
module tes_ctrl #(
    parameter int MAX_ROWS = tes_pkg::MAX_ROWS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [tes_pkg::ROW_COUNT_W-1:0]     row_count,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [tes_pkg::REQ_W-1:0]           req_type,
    input  logic [tes_pkg::ROW_INDEX_W-1:0]     row_index,
    output tes_pkg::walk_cmd_t                  walk_cmd,
    input  tes_pkg::walk_stat_t                 walk_stat,
    output logic                                mem_we,
    output logic [$clog2(MAX_ROWS)-1:0]         mem_waddr,
    output tes_pkg::span_t                      mem_wdata,
    output logic [$clog2(MAX_ROWS)-1:0]         mem_raddr,
    input  tes_pkg::span_t                      mem_rdata,
    input  logic                                res_ready,
    output logic                                res_push,
    output tes_pkg::span_t                      res
);
    import tes_pkg::*;

    localparam int AW = $clog2(MAX_ROWS);
    localparam logic [AW-1:0] LAST_ROW = AW'(MAX_ROWS - 1);

    state_t        state_reg;
    state_t        state_next;
    logic [AW-1:0] clr_addr_reg;
    logic [AW-1:0] clr_addr_next;
    span_t         res_reg;
    span_t         res_next;
    logic          rd_ok_reg;
    logic          rd_ok_next;

    logic [AW-1:0] row_y;
    logic          y_ok;
    logic          index_ok;
    span_t         merged;

    always_comb
    begin
        row_y    = walk_stat.y[AW-1:0];
        y_ok     = !walk_stat.y[COORD_W-1]
                   && ($unsigned(walk_stat.y) < 16'(row_count))
                   && ($unsigned(walk_stat.y) < 16'(MAX_ROWS));
        index_ok = 16'(row_index) < 16'(MAX_ROWS);

        merged.filled = 1'b1;
        if (!mem_rdata.filled)
        begin
            merged.left  = walk_stat.x;
            merged.right = walk_stat.x;
        end
        else
        begin
            merged.left  = (walk_stat.x < mem_rdata.left)  ? walk_stat.x : mem_rdata.left;
            merged.right = (walk_stat.x > mem_rdata.right) ? walk_stat.x : mem_rdata.right;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        res_next      = res_reg;
        rd_ok_next    = rd_ok_reg;
        in_ready      = 1'b0;
        walk_cmd      = '0;
        mem_we        = 1'b0;
        mem_waddr     = clr_addr_reg;
        mem_wdata     = '0;
        mem_raddr     = row_y;
        res_push      = 1'b0;

        unique case (state_reg)
            ST_SWEEP:
            begin
                mem_we = 1'b1;
                if (clr_addr_reg == LAST_ROW)
                begin
                    clr_addr_next = '0;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                mem_raddr = AW'(row_index);
                if (in_valid)
                begin
                    walk_cmd.load = 1'b1;
                    res_next      = '0;
                    rd_ok_next    = index_ok;
                    unique case (req_type)
                        REQ_CLEAR: state_next = ST_CLEAR;
                        REQ_EDGE:  state_next = ST_INIT;
                        REQ_READ:  state_next = ST_RD_DATA;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                if (clr_addr_reg == LAST_ROW)
                begin
                    clr_addr_next = '0;
                    state_next    = ST_DONE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            ST_INIT:
            begin
                walk_cmd.init = 1'b1;
                state_next    = ST_PT_RD;
            end
            ST_PT_RD:
            begin
                if (y_ok)
                begin
                    state_next = ST_PT_WR;
                end
                else if (walk_stat.at_end)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    walk_cmd.step = 1'b1;
                end
            end
            ST_PT_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = row_y;
                mem_wdata = merged;
                if (walk_stat.at_end)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    walk_cmd.step = 1'b1;
                    state_next    = ST_PT_RD;
                end
            end
            ST_RD_DATA:
            begin
                if (rd_ok_reg && mem_rdata.filled)
                begin
                    res_next = mem_rdata;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    res_push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_SWEEP;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg   <= res_next;
        rd_ok_reg <= rd_ok_next;
    end

    assign res = res_reg;

endmodule

### src/triangle_edge_span_table.sv
// channel   direction  handshake              payload
// cfg       in         cfg_wr_en              cfg_wr_data (row_count)
// in        in         in_valid / in_ready    req_type, x_start, y_start, x_end, y_end, row_index
// out       out        out_valid / out_ready  span_valid, span_left, span_right
//
// edge item: a read-modify-write of the span memory through its one read port, a read state
//   then a write state, for each visited point inside the rows; a point outside is only stepped
// clear item: all MAX_ROWS rows written, one row written per cycle; read item: one memory read
// after reset a clearing pass over all MAX_ROWS rows runs with in_ready low
// one item at a time; a finished item waits in the output register while the next is taken
module triangle_edge_span_table #(
    parameter int MAX_ROWS = tes_pkg::MAX_ROWS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [tes_pkg::ROW_COUNT_W-1:0]     cfg_wr_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [tes_pkg::REQ_W-1:0]           req_type,
    input  tes_pkg::coord_t                     x_start,
    input  tes_pkg::coord_t                     y_start,
    input  tes_pkg::coord_t                     x_end,
    input  tes_pkg::coord_t                     y_end,
    input  logic [tes_pkg::ROW_INDEX_W-1:0]     row_index,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                span_valid,
    output tes_pkg::coord_t                     span_left,
    output tes_pkg::coord_t                     span_right
);
    import tes_pkg::*;

    localparam int AW = $clog2(MAX_ROWS);

    logic [ROW_COUNT_W-1:0] row_count_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    span_t                  out_span_reg;

    walk_cmd_t              walk_cmd;
    walk_stat_t             walk_stat;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    span_t                  mem_wdata;
    logic [AW-1:0]          mem_raddr;
    span_t                  mem_rdata;
    logic                   res_ready;
    logic                   res_push;
    span_t                  res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= ROW_COUNT_RST;
        end
        else if (cfg_wr_en)
        begin
            row_count_reg <= cfg_wr_data;
        end
    end

    tes_walker u_walker (
        .clk  (clk),
        .cmd  (walk_cmd),
        .xa   (x_start),
        .ya   (y_start),
        .xb   (x_end),
        .yb   (y_end),
        .stat (walk_stat)
    );

    tes_span_mem #(
        .MAX_ROWS (MAX_ROWS)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    tes_ctrl #(
        .MAX_ROWS (MAX_ROWS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .row_count (row_count_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .row_index (row_index),
        .walk_cmd  (walk_cmd),
        .walk_stat (walk_stat),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .res_ready (res_ready),
        .res_push  (res_push),
        .res       (res)
    );

    // output register
    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_push)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            out_span_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign span_valid = out_span_reg.filled;
    assign span_left  = out_span_reg.left;
    assign span_right = out_span_reg.right;

endmodule

### src/tes_checker.sv
module tes_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic                                span_valid,
    input tes_pkg::coord_t                     span_left,
    input tes_pkg::coord_t                     span_right
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(span_valid)
            && $stable(span_left) && $stable(span_right))
        else $error("result changed while stalled");

    // an empty row reports zero bounds
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !span_valid |-> span_left == 16'sd0 && span_right == 16'sd0)
        else $error("empty result with nonzero bounds");

    // one item at a time
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item taken while busy");

    // a new result only appears after the block has been busy
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared without work");

endmodule

bind triangle_edge_span_table tes_checker u_tes_checker (.*);

### tb/span_table_checker.sv
`timescale 1ns / 1ps

module span_table_checker #(
    parameter int MAX_ROWS = tes_pkg::MAX_ROWS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [tes_pkg::ROW_COUNT_W-1:0] cfg_wr_data,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic [tes_pkg::REQ_W-1:0]       req_type,
    input  tes_pkg::coord_t                 x_start,
    input  tes_pkg::coord_t                 y_start,
    input  tes_pkg::coord_t                 x_end,
    input  tes_pkg::coord_t                 y_end,
    input  logic [tes_pkg::ROW_INDEX_W-1:0] row_index,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic                            span_valid,
    input  tes_pkg::coord_t                 span_left,
    input  tes_pkg::coord_t                 span_right,
    output int                              fail_cnt,
    output int                              pending
);
    import tes_pkg::*;

    logic [ROW_COUNT_W-1:0] row_count_q;
    coord_t                 row_lo [MAX_ROWS];
    coord_t                 row_hi [MAX_ROWS];
    bit                     row_hit [MAX_ROWS];
    span_t                  span_due [$];

    function automatic void note_fail(input string msg);
        fail_cnt++;
        if (fail_cnt <= 10)
            $display("%0t: %s", $time, msg);
    endfunction

    function automatic void widen_row(input int x, input int y);
        int rows_in_use;
        rows_in_use = (row_count_q < MAX_ROWS) ? row_count_q : MAX_ROWS;
        if (y < 0 || y >= rows_in_use)
            return;
        if (!row_hit[y])
        begin
            row_hit[y] = 1'b1;
            row_lo[y]  = coord_t'(x);
            row_hi[y]  = coord_t'(x);
        end
        else
        begin
            if (x < row_lo[y])
                row_lo[y] = coord_t'(x);
            if (x > row_hi[y])
                row_hi[y] = coord_t'(x);
        end
    endfunction

    function automatic void trace_edge(input int xa, input int ya, input int xb, input int yb);
        int dx, dy, sx, sy, d, inc_flat, inc_diag, x, y;
        bit steep;
        dx = (xb > xa) ? xb - xa : xa - xb;
        dy = (yb > ya) ? yb - ya : ya - yb;
        sx = (xa > xb) ? -1 : 1;
        sy = (ya > yb) ? -1 : 1;
        steep = dy > dx;
        if (steep)
        begin
            inc_flat = 2 * dx;
            inc_diag = 2 * (dx - dy);
            d        = 2 * dx - dy;
        end
        else
        begin
            inc_flat = 2 * dy;
            inc_diag = 2 * (dy - dx);
            d        = 2 * dy - dx;
        end
        x = xa;
        y = ya;
        widen_row(x, y);
        while (y != yb)
        begin
            if (d <= 0)
            begin
                d += inc_flat;
                if (steep)
                    y += sy;
                else
                    x += sx;
            end
            else
            begin
                d += inc_diag;
                x += sx;
                y += sy;
            end
            widen_row(x, y);
        end
    endfunction

    function automatic span_t answer_request(input logic [REQ_W-1:0] req,
                                             input coord_t xs, input coord_t ys,
                                             input coord_t xe, input coord_t ye,
                                             input logic [ROW_INDEX_W-1:0] row);
        span_t res;
        res = '0;
        if (req == REQ_CLEAR)
        begin
            for (int i = 0; i < MAX_ROWS; i++)
                row_hit[i] = 1'b0;
        end
        else if (req == REQ_EDGE)
            trace_edge(xs, ys, xe, ye);
        else if (req == REQ_READ)
        begin
            if (row < MAX_ROWS && row_hit[row])
            begin
                res.filled = 1'b1;
                res.left   = row_lo[row];
                res.right  = row_hi[row];
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        span_t want;
        if (!rst_n)
        begin
            row_count_q = ROW_COUNT_RST;
            for (int i = 0; i < MAX_ROWS; i++)
                row_hit[i] = 1'b0;
            span_due.delete();
            fail_cnt = 0;
            pending  = 0;
        end
        else
        begin
            if (cfg_wr_en)
                row_count_q = cfg_wr_data;
            if (out_valid && out_ready)
            begin
                if (span_due.size() == 0)
                    note_fail($sformatf("unexpected item: valid %0b left %0d right %0d",
                                        span_valid, span_left, span_right));
                else
                begin
                    want = span_due.pop_front();
                    if (span_valid !== want.filled || span_left !== want.left ||
                        span_right !== want.right)
                        note_fail($sformatf({"span mismatch: expected %0b %0d %0d,",
                                             " got %0b %0d %0d"},
                                            want.filled, want.left, want.right,
                                            span_valid, span_left, span_right));
                end
            end
            if (in_valid && in_ready)
                span_due.push_back(answer_request(req_type, x_start, y_start, x_end, y_end,
                                                  row_index));
            pending = span_due.size();
        end
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import tes_pkg::*;

    localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 165;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_CYCLES = 300;
    localparam int CALM_FROM   = 600;
    localparam int CALM_TO     = 750;

    typedef logic [ROW_INDEX_W-1:0] row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [ROW_COUNT_W-1:0] cfg_wr_data;
    logic                   in_valid;
    logic                   in_ready;
    logic [REQ_W-1:0]       req_type;
    coord_t                 x_start;
    coord_t                 y_start;
    coord_t                 x_end;
    coord_t                 y_end;
    row_t                   row_index;
    logic                   out_valid;
    logic                   out_ready;
    logic                   span_valid;
    coord_t                 span_left;
    coord_t                 span_right;
    int                     fail_cnt;
    int                     pending;
    bit                     tx_calm;
    int                     items_sent;
    int                     row_plan [PHASES] = '{1024, 8, 1, 2047, 0, 300, 1025, 1};

    always #2 clk = ~clk;

    triangle_edge_span_table i_dut (.*);

    span_table_checker i_checker (.*);

    function automatic coord_t rnd16();
        return coord_t'($urandom);
    endfunction

    function automatic coord_t clamp16(input int v);
        return coord_t'(v > 32767 ? 32767 : (v < -32768 ? -32768 : v));
    endfunction

    task automatic drive_item(input logic [REQ_W-1:0] req, input coord_t xs, input coord_t ys,
                              input coord_t xe, input coord_t ye, input row_t row);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 3);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        req_type  <= req;
        x_start   <= xs;
        y_start   <= ys;
        x_end     <= xe;
        y_end     <= ye;
        row_index <= row;
        do @(posedge clk); while (!in_ready);
        if (req != REQ_SPARE)
            items_sent++;
    endtask

    task automatic send_edge(input coord_t xs, input coord_t ys, input coord_t xe,
                             input coord_t ye);
        drive_item(REQ_EDGE, xs, ys, xe, ye, row_t'($urandom));
    endtask

    task automatic send_read(input row_t row);
        drive_item(REQ_READ, rnd16(), rnd16(), rnd16(), rnd16(), row);
    endtask

    task automatic send_clear();
        drive_item(REQ_CLEAR, rnd16(), rnd16(), rnd16(), rnd16(), row_t'($urandom));
    endtask

    task automatic drain_all();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_rows(input int v);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v[ROW_COUNT_W-1:0];
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // an optional clear, every edge of one triangle, then reads of its rows and the rows beside them
    task automatic triangle_burst(input int rows);
        int vx [3];
        int vy [3];
        int base_x, base_y, lo, hi, r;
        base_y = $urandom_range(0, rows + 4) - 2;
        if ($urandom_range(0, 7) == 0)
            base_x = int'(rnd16());
        else
            base_x = $urandom_range(0, 400) - 200;
        for (int k = 0; k < 3; k++)
        begin
            vx[k] = clamp16(base_x + $urandom_range(0, 120) - 60);
            vy[k] = clamp16(base_y + $urandom_range(0, 40) - 20);
        end
        if ($urandom_range(0, 3) == 0)
            send_clear();
        for (int k = 0; k < 3; k++)
            send_edge(coord_t'(vx[k]), coord_t'(vy[k]),
                      coord_t'(vx[(k + 1) % 3]), coord_t'(vy[(k + 1) % 3]));
        lo = vy[0];
        hi = vy[0];
        for (int k = 1; k < 3; k++)
        begin
            if (vy[k] < lo)
                lo = vy[k];
            if (vy[k] > hi)
                hi = vy[k];
        end
        repeat ($urandom_range(2, 6))
        begin
            r = lo - 1 + $urandom_range(0, hi - lo + 2);
            if (r < 0)
                r = 0;
            if (r > 1023)
                r = 1023;
            send_read(r[ROW_INDEX_W-1:0]);
        end
    endtask

    task automatic noise_item();
        coord_t xs, ys;
        xs = rnd16();
        ys = rnd16();
        case ($urandom_range(0, 2))
            0: drive_item(REQ_SPARE, xs, ys, rnd16(), rnd16(), row_t'($urandom));
            1: send_edge(xs, ys, clamp16(int'(xs) + $urandom_range(0, 16) - 8),
                         clamp16(int'(ys) + $urandom_range(0, 16) - 8));
            default: send_read(row_t'($urandom));
        endcase
    endtask

    initial
    begin
        int rows, eff, quota;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = ROW_COUNT_RST;
        in_valid    = 1'b0;
        req_type    = REQ_CLEAR;
        x_start     = '0;
        y_start     = '0;
        x_end       = '0;
        y_end       = '0;
        row_index   = '0;
        tx_calm     = 1'b0;
        items_sent  = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_read(0);
        send_edge(5, 3, 5, 3);
        send_read(3);
        send_edge(-10, 7, 20, 7);
        send_read(7);
        send_edge(0, 0, 3, 10);
        send_edge(-32768, 0, 32767, 4);
        send_read(0);
        send_read(4);
        send_edge(32767, -32768, -32768, 32767);
        send_read(1023);
        send_edge(100, 1020, 90, 1030);
        send_edge(3, -5, 8, 2);
        send_read(2);
        send_read(1020);
        drive_item(REQ_SPARE, rnd16(), rnd16(), rnd16(), rnd16(), row_t'($urandom));
        send_read(1);
        send_clear();
        send_read(0);
        send_read(1023);
        send_edge(-32768, 1, -32768, 1);
        send_edge(32767, 1, 32767, 1);
        send_read(1);
        send_edge(7, 30, -7, 20);
        send_read(25);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_all();
            rows = (ph == PHASES - 1) ? $urandom_range(1, 1024) : row_plan[ph];
            write_rows(rows);
            eff     = (rows > MAX_ROWS_DEF) ? MAX_ROWS_DEF : rows;
            tx_calm = (ph == 2);
            quota   = items_sent + PHASE_ITEMS;
            while (items_sent < quota)
            begin
                if ($urandom_range(0, 9) < 7)
                    triangle_burst(eff);
                else
                    noise_item();
            end
        end
        drain_all();
        repeat (40) @(posedge clk);
        if (fail_cnt == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int gap, taken;
        out_ready = 1'b0;
        taken     = 0;
        wait (rst_n);
        forever
        begin
            if (taken == HOLD_AT)
                gap = HOLD_CYCLES;
            else if (taken >= CALM_FROM && taken < CALM_TO)
                gap = 0;
            else
                gap = $urandom_range(0, 3);
            @(negedge clk);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            taken++;
        end
    end

    initial
    begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### files.f
src/tes_pkg.sv
src/tes_span_mem.sv
src/tes_walker.sv
src/tes_ctrl.sv
src/triangle_edge_span_table.sv
src/tes_checker.sv
tb/span_table_checker.sv
tb/tb_top.sv
